FILE: sv/bqgp_pkg.sv
// ----------------------------------------------------------------------------
// bqgp_pkg
// Shared types, widths and fixed-point constants of the quality-gated
// biosignal preprocessor.
// ----------------------------------------------------------------------------
package bqgp_pkg;

	// Block geometry
	localparam int CHANNELS_DEFAULT = 3;
	localparam int QUEUE_DEPTH      = 4;

	// Field widths
	localparam int CHAN_W     = 2;
	localparam int SAMPLE_W   = 16;
	localparam int GAIN_W     = 7;
	localparam int TH_W       = 15;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;
	localparam int OUT_DATA_W = 24;

	// Datapath widths: Q11.20 state, Q.20 coefficients
	localparam int STATE_W = 32;
	localparam int FRAC    = 20;
	localparam int COEF_W  = 22;
	localparam int PROD_W  = 54;
	localparam int ACC_W   = 58;
	localparam int GAIN_SH = 14;

	// Filter coefficients, Q.20 rounded to nearest
	localparam logic signed [COEF_W-1:0] K_LP_A = 22'sd957455;
	localparam logic signed [COEF_W-1:0] K_LP_B = 22'sd91121;
	localparam logic signed [COEF_W-1:0] K_C0   = 22'sd326071;
	localparam logic signed [COEF_W-1:0] K_C1   = -22'sd335936;
	localparam logic signed [COEF_W-1:0] K_D    = 22'sd210042;
	localparam logic signed [COEF_W-1:0] K_A00  = 22'sd1627817;
	localparam logic signed [COEF_W-1:0] K_A01  = -22'sd628492;
	localparam logic signed [COEF_W-1:0] K_PC   = 22'sd39612;
	localparam logic signed [COEF_W-1:0] K_PD   = 22'sd20195;
	localparam logic signed [COEF_W-1:0] K_PA   = 22'sd1008186;
	localparam logic signed [COEF_W-1:0] K_ONE  = 22'sd1048576;

	localparam logic [GAIN_W-1:0] GAIN_FULL = 7'd64;

	// Rounding offsets preloaded into the accumulator
	localparam logic signed [ACC_W-1:0] RND_HALF  = ACC_W'(1) <<< (FRAC - 1);
	localparam logic signed [ACC_W-1:0] GAIN_HALF = ACC_W'(1) <<< (GAIN_SH - 1);

	// Register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CLIP_LOW      = 2'd0,
		REG_CLIP_HIGH     = 2'd1,
		REG_LATCH_RELEASE = 2'd2,
		REG_LATCH_TRIP    = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic signed [SAMPLE_W-1:0] clip_low;
		logic signed [SAMPLE_W-1:0] clip_high;
		logic [TH_W-1:0]            latch_release;
		logic [TH_W-1:0]            latch_trip;
	} cfg_t;

	typedef struct packed {
		logic [CHAN_W-1:0]          chan;
		logic signed [SAMPLE_W-1:0] sample;
	} item_t;

	// Saturate a wide value to the signed 32-bit range
	function automatic logic signed [STATE_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
		logic signed [ACC_W-1:0] hi;
		logic signed [ACC_W-1:0] lo;
		hi = ACC_W'(64'sh7FFF_FFFF);
		lo = -hi - ACC_W'(1);
		if (v > hi) begin
			return 32'sh7FFF_FFFF;
		end else if (v < lo) begin
			return 32'sh8000_0000;
		end
		return v[STATE_W-1:0];
	endfunction

	// Drop 20 fraction bits (offset already in the sum) and saturate
	function automatic logic signed [STATE_W-1:0] rnd20(input logic signed [ACC_W-1:0] v);
		return sat32(v >>> FRAC);
	endfunction

endpackage

FILE: sv/biosignal_quality_gated_preproc.sv
// ----------------------------------------------------------------------------
// biosignal_quality_gated_preproc
// Multi-channel sample conditioner with baseline removal, bandpass, power
// tracking, hysteresis quality latch and a ramped output gate.
// ----------------------------------------------------------------------------
// Usage:
//   Input words arrive on s_tvalid/s_tready: s_tdata is the Q4.12 sample,
//   s_tuser the channel. Words for channels at or above CHANNELS are taken
//   and dropped without a result. Each other word gives one result word on
//   m_tvalid/m_tready: m_tdata holds the clipped conditioned sample, the
//   quality mask and the gate gain; m_tuser repeats the channel.
//   Configuration registers (clip limits, latch thresholds) are written
//   through cfg_we/cfg_index/cfg_data while no word is in flight.
//   One shared 22x32 multiplier and accumulator are stepped by a
//   sequencer through 21 steps after a load step; a new word is taken
//   only once the last one has left the sequencer for the output register.
//   A four-word queue sits between intake and sequencer, and the result
//   sits in an output register: the sequencer starts the next word while a
//   result waits, and stalls only in its last step if the receiver holds off.
//   Reset (arst_n low) clears all channel state to zero, mask good, gain 64,
//   and loads the register defaults; no word is lost once accepted.
// ----------------------------------------------------------------------------
module biosignal_quality_gated_preproc #(
	parameter int CHANNELS = bqgp_pkg::CHANNELS_DEFAULT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Input word
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [bqgp_pkg::SAMPLE_W-1:0]   s_tdata,   // [15:0] sample
	input  logic [bqgp_pkg::CHAN_W-1:0]     s_tuser,   // [1:0] channel
	// Result word
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [bqgp_pkg::OUT_DATA_W-1:0] m_tdata,   // [15:0] conditioned,
	                                                   // [16] quality_good,
	                                                   // [23:17] gain_steps
	output logic [bqgp_pkg::CHAN_W-1:0]     m_tuser,   // [1:0] out_channel
	// Register writes
	input  logic                            cfg_we,
	input  logic [bqgp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bqgp_pkg::CFG_DATA_W-1:0] cfg_data
);

	bqgp_pkg::cfg_t  cfg_q;
	bqgp_pkg::item_t front_item;
	bqgp_pkg::item_t queue_item;
	logic            front_valid;
	logic            front_ready;
	logic            queue_valid;
	logic            queue_ready;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.clip_low      <= -16'sd8192;
			cfg_q.clip_high     <= 16'sd8192;
			cfg_q.latch_release <= 15'd614;
			cfg_q.latch_trip    <= 15'd3686;
		end else if (cfg_we) begin
			case (bqgp_pkg::cfg_reg_t'(cfg_index))
				bqgp_pkg::REG_CLIP_LOW:      cfg_q.clip_low      <= cfg_data;
				bqgp_pkg::REG_CLIP_HIGH:     cfg_q.clip_high     <= cfg_data;
				bqgp_pkg::REG_LATCH_RELEASE: cfg_q.latch_release <= cfg_data[bqgp_pkg::TH_W-1:0];
				bqgp_pkg::REG_LATCH_TRIP:    cfg_q.latch_trip    <= cfg_data[bqgp_pkg::TH_W-1:0];
				default: begin
				end
			endcase
		end
	end

	bqgp_front #(
		.CHANNELS(CHANNELS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.out_valid(front_valid),
		.out_ready(front_ready),
		.out_item (front_item)
	);

	bqgp_fifo #(
		.WIDTH($bits(bqgp_pkg::item_t)),
		.DEPTH(bqgp_pkg::QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_valid(front_valid),
		.wr_ready(front_ready),
		.wr_data (front_item),
		.rd_valid(queue_valid),
		.rd_ready(queue_ready),
		.rd_data (queue_item)
	);

	bqgp_back #(
		.CHANNELS(CHANNELS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.in_valid(queue_valid),
		.in_ready(queue_ready),
		.in_item (queue_item),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	// Gate gain never leaves 0..64
	a_gain_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[23:17] <= bqgp_pkg::GAIN_FULL))
		else $error("gate gain above unity");

	// A good mask has just raised the gain above zero; a bad one lowered it below unity
	a_gain_mask: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[16] ? (m_tdata[23:17] != '0)
		                          : (m_tdata[23:17] != bqgp_pkg::GAIN_FULL)))
		else $error("gate gain disagrees with quality mask");

	// Only existing channels produce results
	a_chan_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (int'(m_tuser) < CHANNELS))
		else $error("result for a channel that does not exist");

endmodule

FILE: sv/bqgp_fifo.sv
// ----------------------------------------------------------------------------
// bqgp_fifo
// Short register queue between the intake and the sequencer.
// ----------------------------------------------------------------------------
module bqgp_fifo #(
	parameter int WIDTH = 18,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_valid,
	output logic             wr_ready,
	input  logic [WIDTH-1:0] wr_data,
	output logic             rd_valid,
	input  logic             rd_ready,
	output logic [WIDTH-1:0] rd_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign wr_ready = (count_q != CNT_W'(DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	// Store a word
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

FILE: sv/bqgp_front.sv
// ----------------------------------------------------------------------------
// bqgp_front
// Intake stage: takes input words, drops those for channels that do not
// exist and hands the rest to the queue.
// ----------------------------------------------------------------------------
module bqgp_front #(
	parameter int CHANNELS = bqgp_pkg::CHANNELS_DEFAULT
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [bqgp_pkg::SAMPLE_W-1:0] s_tdata,
	input  logic [bqgp_pkg::CHAN_W-1:0]   s_tuser,
	output logic                          out_valid,
	input  logic                          out_ready,
	output bqgp_pkg::item_t               out_item
);

	logic            stg_vld_q;
	bqgp_pkg::item_t stg_item_q;
	logic            in_range;

	assign in_range  = (int'(s_tuser) < CHANNELS);
	assign s_tready  = !stg_vld_q || out_ready;
	assign out_valid = stg_vld_q;
	assign out_item  = stg_item_q;

	// Hold a word until the queue takes it; drop unknown channels
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stg_vld_q <= 1'b0;
		end else if (s_tready) begin
			stg_vld_q <= s_tvalid && in_range;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			stg_item_q.chan   <= s_tuser;
			stg_item_q.sample <= s_tdata;
		end
	end

endmodule

FILE: sv/bqgp_back.sv
// ----------------------------------------------------------------------------
// bqgp_back
// Per-channel filter sequencer: one shared multiplier and accumulator step
// through baseline, bandpass, power, latch, gain and output clip.
// ----------------------------------------------------------------------------
module bqgp_back #(
	parameter int CHANNELS = bqgp_pkg::CHANNELS_DEFAULT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  bqgp_pkg::cfg_t                  cfg,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  bqgp_pkg::item_t                 in_item,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [bqgp_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic [bqgp_pkg::CHAN_W-1:0]     m_tuser
);

	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int SW    = bqgp_pkg::STATE_W;
	localparam int AW    = bqgp_pkg::ACC_W;
	localparam int GW    = bqgp_pkg::GAIN_W;
	localparam int PW    = bqgp_pkg::PROD_W;

	typedef enum logic [4:0] {
		ST_IDLE, ST_LP0, ST_LP1, ST_LP2, ST_LPW,
		ST_BP0, ST_BP1, ST_BP2, ST_BP3, ST_BP4, ST_BP5, ST_BP6, ST_BPW,
		ST_ABS, ST_PW0, ST_PW1, ST_PW2, ST_PW3, ST_PW4, ST_PW5,
		ST_GS, ST_OUT
	} st_t;

	st_t state_q;

	// Per-channel state
	logic signed [SW-1:0] bl_q [CHANNELS];
	logic signed [SW-1:0] s0_q [CHANNELS];
	logic signed [SW-1:0] s1_q [CHANNELS];
	logic signed [SW-1:0] pw_q [CHANNELS];
	logic                 mask_q [CHANNELS];
	logic [GW-1:0]        gain_arr_q [CHANNELS];

	// Working registers
	logic [IDX_W-1:0]                  c_q;
	logic [bqgp_pkg::CHAN_W-1:0]       chan_q;
	logic signed [SW-1:0]              xs_q;
	logic signed [SW-1:0]              x_q;
	logic signed [SW-1:0]              xbp_q;
	logic signed [SW-1:0]              r_q;
	logic signed [SW-1:0]              ar_q;
	logic signed [SW-1:0]              q_q;
	logic                              good_q;
	logic [GW-1:0]                     gain_q;
	logic signed [bqgp_pkg::PROD_W-1:0] prod_q;
	logic signed [AW-1:0]              acc_q;
	logic                              m_vld_q;
	logic [bqgp_pkg::OUT_DATA_W-1:0]   m_data_q;

	// Multiplier operands
	logic signed [bqgp_pkg::COEF_W-1:0] mcoef;
	logic signed [SW-1:0]               mdata;

	// Latch and gain decision
	logic signed [SW-1:0] rel_lvl;
	logic signed [SW-1:0] trip_lvl;
	logic                 good_d;
	logic [GW-1:0]        gain_cur;
	logic [GW-1:0]        gain_d;

	// Output scaling and clip
	logic signed [AW-1:0]                   y_full;
	logic signed [bqgp_pkg::SAMPLE_W-1:0]   y_clip;
	logic                                   out_free;

	assign in_ready = (state_q == ST_IDLE);
	assign m_tvalid = m_vld_q;
	assign m_tdata  = m_data_q;
	assign out_free = !m_vld_q || m_tready;

	// Pick multiplier operands for this step
	always_comb begin
		mcoef = '0;
		mdata = '0;
		case (state_q)
			ST_LP0: begin mcoef = bqgp_pkg::K_LP_A; mdata = bl_q[c_q]; end
			ST_LP1: begin mcoef = bqgp_pkg::K_LP_B; mdata = xs_q; end
			ST_BP0: begin mcoef = bqgp_pkg::K_C0;   mdata = s0_q[c_q]; end
			ST_BP1: begin mcoef = bqgp_pkg::K_C1;   mdata = s1_q[c_q]; end
			ST_BP2: begin mcoef = bqgp_pkg::K_D;    mdata = x_q; end
			ST_BP3: begin mcoef = bqgp_pkg::K_A00;  mdata = s0_q[c_q]; end
			ST_BP4: begin mcoef = bqgp_pkg::K_A01;  mdata = s1_q[c_q]; end
			ST_BP5: begin mcoef = bqgp_pkg::K_ONE;  mdata = x_q; end
			ST_PW0: begin mcoef = bqgp_pkg::K_PC;   mdata = pw_q[c_q]; end
			ST_PW1: begin mcoef = bqgp_pkg::K_PD;   mdata = ar_q; end
			ST_PW2: begin mcoef = bqgp_pkg::K_PA;   mdata = pw_q[c_q]; end
			ST_PW3: begin mcoef = bqgp_pkg::K_ONE;  mdata = ar_q; end
			ST_PW5: begin
				mcoef = $signed({{(bqgp_pkg::COEF_W - GW){1'b0}}, gain_q});
				mdata = xbp_q;
			end
			default: begin mcoef = '0; mdata = '0; end
		endcase
	end

	// Hysteresis latch on the power estimate, then ramp the gate gain
	assign rel_lvl  = $signed({{(SW - bqgp_pkg::TH_W - 8){1'b0}}, cfg.latch_release, 8'd0});
	assign trip_lvl = $signed({{(SW - bqgp_pkg::TH_W - 8){1'b0}}, cfg.latch_trip, 8'd0});
	assign gain_cur = gain_arr_q[c_q];

	always_comb begin
		if (q_q < rel_lvl) begin
			good_d = 1'b1;
		end else if ((q_q >= trip_lvl) || !mask_q[c_q]) begin
			good_d = 1'b0;
		end else begin
			good_d = 1'b1;
		end
		if (good_d) begin
			gain_d = (gain_cur >= bqgp_pkg::GAIN_FULL) ? bqgp_pkg::GAIN_FULL
			                                            : gain_cur + GW'(1);
		end else if (gain_cur == '0) begin
			gain_d = '0;
		end else if (gain_cur > bqgp_pkg::GAIN_FULL) begin
			gain_d = bqgp_pkg::GAIN_FULL;
		end else begin
			gain_d = gain_cur - GW'(1);
		end
	end

	// Scale by gain/64 with rounding, then clip; the low limit wins
	assign y_full = acc_q >>> bqgp_pkg::GAIN_SH;

	always_comb begin
		if (y_full < AW'(cfg.clip_low)) begin
			y_clip = cfg.clip_low;
		end else if (y_full > AW'(cfg.clip_high)) begin
			y_clip = cfg.clip_high;
		end else begin
			y_clip = y_full[bqgp_pkg::SAMPLE_W-1:0];
		end
	end

	// Sequence the steps and write back channel state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			m_vld_q <= 1'b0;
			for (int i = 0; i < CHANNELS; i++) begin
				bl_q[i]       <= '0;
				s0_q[i]       <= '0;
				s1_q[i]       <= '0;
				pw_q[i]       <= '0;
				mask_q[i]     <= 1'b1;
				gain_arr_q[i] <= bqgp_pkg::GAIN_FULL;
			end
		end else begin
			// Drop the result word once taken, unless a new one replaces it
			if (m_vld_q && m_tready && !(state_q == ST_OUT && out_free)) begin
				m_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: if (in_valid) state_q <= ST_LP0;
				ST_LP0:  state_q <= ST_LP1;
				ST_LP1:  state_q <= ST_LP2;
				ST_LP2:  state_q <= ST_LPW;
				ST_LPW: begin
					bl_q[c_q] <= bqgp_pkg::rnd20(acc_q);
					state_q   <= ST_BP0;
				end
				ST_BP0:  state_q <= ST_BP1;
				ST_BP1:  state_q <= ST_BP2;
				ST_BP2:  state_q <= ST_BP3;
				ST_BP3:  state_q <= ST_BP4;
				ST_BP4:  state_q <= ST_BP5;
				ST_BP5:  state_q <= ST_BP6;
				ST_BP6:  state_q <= ST_BPW;
				ST_BPW: begin
					s1_q[c_q] <= s0_q[c_q];
					s0_q[c_q] <= bqgp_pkg::rnd20(acc_q);
					state_q   <= ST_ABS;
				end
				ST_ABS:  state_q <= ST_PW0;
				ST_PW0:  state_q <= ST_PW1;
				ST_PW1:  state_q <= ST_PW2;
				ST_PW2:  state_q <= ST_PW3;
				ST_PW3:  state_q <= ST_PW4;
				ST_PW4: begin
					mask_q[c_q]     <= good_d;
					gain_arr_q[c_q] <= gain_d;
					state_q         <= ST_PW5;
				end
				ST_PW5: begin
					pw_q[c_q] <= bqgp_pkg::rnd20(acc_q);
					state_q   <= ST_GS;
				end
				ST_GS:   state_q <= ST_OUT;
				ST_OUT: begin
					if (out_free) begin
						m_vld_q <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers: multiplier, accumulator and intermediates
	always_ff @(posedge clk) begin
		prod_q <= PW'(mcoef) * PW'(mdata);
		case (state_q)
			ST_IDLE: begin
				c_q    <= IDX_W'(in_item.chan);
				chan_q <= in_item.chan;
				xs_q   <= {{(SW - bqgp_pkg::SAMPLE_W - 8){in_item.sample[bqgp_pkg::SAMPLE_W-1]}},
				           in_item.sample, 8'd0};
				acc_q  <= bqgp_pkg::RND_HALF;
			end
			ST_LPW: begin
				x_q   <= bqgp_pkg::sat32(AW'(xs_q) - AW'(bqgp_pkg::rnd20(acc_q)));
				acc_q <= bqgp_pkg::RND_HALF;
			end
			ST_BP4: begin
				xbp_q <= bqgp_pkg::rnd20(acc_q);
				acc_q <= bqgp_pkg::RND_HALF + AW'(prod_q);
			end
			ST_BPW: begin
				r_q   <= bqgp_pkg::sat32(AW'(x_q) - AW'(xbp_q));
				acc_q <= bqgp_pkg::RND_HALF;
			end
			ST_ABS: begin
				if (r_q == 32'sh8000_0000) begin
					ar_q <= 32'sh7FFF_FFFF;
				end else begin
					ar_q <= r_q[SW-1] ? -r_q : r_q;
				end
			end
			ST_PW3: begin
				q_q   <= bqgp_pkg::rnd20(acc_q);
				acc_q <= bqgp_pkg::RND_HALF + AW'(prod_q);
			end
			ST_PW4: begin
				acc_q  <= acc_q + AW'(prod_q);
				good_q <= good_d;
				gain_q <= gain_d;
			end
			ST_PW5: begin
				acc_q <= bqgp_pkg::GAIN_HALF;
			end
			ST_LP1, ST_LP2, ST_BP1, ST_BP2, ST_BP3, ST_BP5, ST_BP6,
			ST_PW1, ST_PW2, ST_GS: begin
				acc_q <= acc_q + AW'(prod_q);
			end
			ST_OUT: begin
				if (out_free) begin
					m_data_q <= {gain_q, good_q, y_clip};
					m_tuser  <= chan_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule
